// ----- rtl/nhff_pkg.sv -----
// ----------------------------------------------------------------------------
// nhff_pkg
// Shared types and constants for the neighbor hole fill filter.
// ----------------------------------------------------------------------------
`default_nettype none

package nhff_pkg;

    localparam int IMG_W_W     = 11;
    localparam int IMG_H_W     = 13;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int CHAN_W      = 8;
    localparam int PIX_W       = 3 * CHAN_W;
    localparam int SUM_W       = 10;
    localparam int PROD_W      = 18;

    localparam logic [IMG_W_W-1:0] IMG_W_RESET = 11'd1024;
    localparam logic [IMG_H_W-1:0] IMG_H_RESET = 13'd768;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    localparam logic [CHAN_W-1:0] RED_FLOOR  = 8'd16;
    localparam logic [SUM_W-1:0]  SUM_LIMIT  = 10'd600;
    localparam logic [7:0]        GRAY_RECIP = 8'd205;
    localparam int                GRAY_SHIFT = 10;

endpackage

`default_nettype wire

// ----- rtl/neighbor_hole_fill_filter_unit.sv -----
// ----------------------------------------------------------------------------
// neighbor_hole_fill_filter_unit
// Streaming hole fill filter over the four direct neighbors of each pixel.
//
// Pixels arrive in raster order on the s_ channel, one beat per pixel; a beat
// with s_op set to drain flushes one pixel of the final row once the frame is
// full. Results leave on the m_ channel one row behind the input, with
// m_frame_end on the last pixel of the frame. Frame size is set through the
// cfg_ write channel while the block is idle; a write to the width or height
// register restarts the frame, and s_ready is low while cfg_valid is high.
// The block takes one beat per clock while s_ready is high. Each pixel beat
// reads the center line memory at its column and the next one, and the line
// above at its column; each result passes through the read stage and then
// the output register before the receiver can take it.
// A receiver stall holds the output register and then the read stage, and
// s_ready falls once both are full. Reset clears the counters and the valid
// flags; the line memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module neighbor_hole_fill_filter_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [nhff_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [nhff_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_op,
    input  wire logic [nhff_pkg::CHAN_W-1:0]       s_red,
    input  wire logic [nhff_pkg::CHAN_W-1:0]       s_green,
    input  wire logic [nhff_pkg::CHAN_W-1:0]       s_blue,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [nhff_pkg::CHAN_W-1:0]            m_out_red,
    output logic [nhff_pkg::CHAN_W-1:0]            m_out_green,
    output logic [nhff_pkg::CHAN_W-1:0]            m_out_blue,
    output logic                                   m_frame_end
);

    localparam int IDX_W = $clog2(MAX_WIDTH);
    localparam int CNT_W = $clog2(MAX_WIDTH + 1);
    localparam int EW    = (CNT_W > nhff_pkg::IMG_W_W) ? CNT_W : nhff_pkg::IMG_W_W;
    localparam int CW    = nhff_pkg::CHAN_W;

    logic [nhff_pkg::IMG_W_W-1:0] cfg_w_reg;
    logic [nhff_pkg::IMG_H_W-1:0] cfg_h_reg;
    logic [IDX_W-1:0]             col_reg, col_next;
    logic [nhff_pkg::IMG_H_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0]             drain_reg, drain_next;

    logic [nhff_pkg::PIX_W-1:0] center_mem [MAX_WIDTH];
    logic [CW-1:0]              above_mem [MAX_WIDTH];

    logic                       s1_valid_reg;
    logic                       s1_drain_reg;
    logic                       s1_last_reg;
    logic                       s1_interior_reg;
    logic [IDX_W-1:0]           s1_x_reg;
    logic [CW-1:0]              s1_red_reg;
    logic [nhff_pkg::PIX_W-1:0] cen_rd_reg;
    logic [CW-1:0]              right_rd_reg;
    logic [CW-1:0]              above_rd_reg;
    logic [CW-1:0]              left_red_reg;

    logic                       m_valid_reg;
    logic [CW-1:0]              m_red_reg;
    logic [CW-1:0]              m_green_reg;
    logic [CW-1:0]              m_blue_reg;
    logic                       m_last_reg;

    logic [CNT_W-1:0]             eff_w;
    logic [nhff_pkg::IMG_H_W-1:0] eff_h;
    logic [CNT_W-1:0]             col_inc;
    logic [CNT_W-1:0]             drain_inc;
    logic                         col_wrap;
    logic                         full;
    logic                         drain_avail;
    logic                         drain_last;
    logic                         interior;
    logic                         is_drain;
    logic                         cfg_acc;
    logic                         cfg_restart;
    logic                         s_acc;
    logic                         push;
    logic                         pix_wr;
    logic                         out_free;
    logic                         s1_adv;
    logic [IDX_W-1:0]             rd_addr_a;
    logic [IDX_W-1:0]             rd_addr_b;
    logic [CW-1:0]                cred;
    logic [nhff_pkg::SUM_W-1:0]   sum;
    logic [nhff_pkg::PROD_W-1:0]  prod;
    logic [CW-1:0]                gray;
    logic                         make_gray;

    assign cfg_ready   = 1'b1;
    assign cfg_acc     = cfg_valid && cfg_ready;
    assign cfg_restart = cfg_acc && ((cfg_index == nhff_pkg::REG_IMAGE_WIDTH)
                                  || (cfg_index == nhff_pkg::REG_IMAGE_HEIGHT));

    assign eff_w = (cfg_w_reg == '0) ? CNT_W'(1)
                 : (EW'(cfg_w_reg) > EW'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH)
                 : CNT_W'(cfg_w_reg);
    assign eff_h = (cfg_h_reg == '0) ? nhff_pkg::IMG_H_W'(1) : cfg_h_reg;

    assign col_inc     = CNT_W'(col_reg) + CNT_W'(1);
    assign col_wrap    = col_inc >= eff_w;
    assign full        = row_reg >= eff_h;
    assign drain_inc   = drain_reg + CNT_W'(1);
    assign drain_avail = full && (drain_reg < eff_w);
    assign drain_last  = drain_inc == eff_w;
    assign interior    = (row_reg >= nhff_pkg::IMG_H_W'(2)) && (row_reg < eff_h)
                      && (col_reg != '0) && (col_inc < eff_w);

    assign is_drain = (nhff_pkg::op_t'(s_op) == nhff_pkg::OP_DRAIN);
    assign out_free = !m_valid_reg || m_ready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_ready  = (!s1_valid_reg || out_free) && !cfg_valid;
    assign s_acc    = s_valid && s_ready;
    assign push     = s_acc && (is_drain ? drain_avail
                                         : (!full && (row_reg != '0)));
    assign pix_wr   = s_acc && !is_drain && !full;

    assign rd_addr_a = is_drain ? drain_reg[IDX_W-1:0] : col_reg;
    assign rd_addr_b = col_inc[IDX_W-1:0];

    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        drain_next = drain_reg;
        if (cfg_restart) begin
            col_next   = '0;
            row_next   = '0;
            drain_next = '0;
        end else if (s_acc) begin
            if (is_drain) begin
                if (drain_avail) begin
                    drain_next = drain_inc;
                    if (drain_last) begin
                        col_next   = '0;
                        row_next   = '0;
                        drain_next = '0;
                    end
                end
            end else if (!full) begin
                if (col_wrap) begin
                    col_next = '0;
                    row_next = row_reg + nhff_pkg::IMG_H_W'(1);
                end else begin
                    col_next = col_inc[IDX_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_w_reg <= nhff_pkg::IMG_W_RESET;
            cfg_h_reg <= nhff_pkg::IMG_H_RESET;
            col_reg   <= '0;
            row_reg   <= '0;
            drain_reg <= '0;
        end else begin
            if (cfg_acc && (cfg_index == nhff_pkg::REG_IMAGE_WIDTH)) begin
                cfg_w_reg <= cfg_data[nhff_pkg::IMG_W_W-1:0];
            end
            if (cfg_acc && (cfg_index == nhff_pkg::REG_IMAGE_HEIGHT)) begin
                cfg_h_reg <= cfg_data[nhff_pkg::IMG_H_W-1:0];
            end
            col_reg   <= col_next;
            row_reg   <= row_next;
            drain_reg <= drain_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_wr) begin
            center_mem[col_reg] <= {s_red, s_green, s_blue};
        end
        if (push) begin
            cen_rd_reg   <= center_mem[rd_addr_a];
            right_rd_reg <= center_mem[rd_addr_b][nhff_pkg::PIX_W-1 -: CW];
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && !s1_drain_reg) begin
            above_mem[s1_x_reg] <= cred;
        end
        if (push) begin
            above_rd_reg <= above_mem[col_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (push) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            s1_drain_reg    <= is_drain;
            s1_last_reg     <= is_drain && drain_last;
            s1_interior_reg <= !is_drain && interior;
            s1_x_reg        <= col_reg;
            s1_red_reg      <= s_red;
        end
    end

    assign cred      = cen_rd_reg[nhff_pkg::PIX_W-1 -: CW];
    assign sum       = nhff_pkg::SUM_W'(left_red_reg) + nhff_pkg::SUM_W'(right_rd_reg)
                     + nhff_pkg::SUM_W'(above_rd_reg) + nhff_pkg::SUM_W'(s1_red_reg);
    assign prod      = nhff_pkg::PROD_W'(sum) * nhff_pkg::PROD_W'(nhff_pkg::GRAY_RECIP);
    assign gray      = CW'(prod >> nhff_pkg::GRAY_SHIFT);
    assign make_gray = s1_interior_reg && (cred > nhff_pkg::RED_FLOOR)
                    && (sum <= nhff_pkg::SUM_LIMIT);

    always_ff @(posedge aclk) begin
        if (s1_adv && !s1_drain_reg) begin
            left_red_reg <= cred;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            if (make_gray) begin
                m_red_reg   <= gray;
                m_green_reg <= gray;
                m_blue_reg  <= gray;
            end else begin
                m_red_reg   <= cen_rd_reg[3*CW-1 -: CW];
                m_green_reg <= cen_rd_reg[2*CW-1 -: CW];
                m_blue_reg  <= cen_rd_reg[CW-1 -: CW];
            end
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_red   = m_red_reg;
    assign m_out_green = m_green_reg;
    assign m_out_blue  = m_blue_reg;
    assign m_frame_end = m_last_reg;

    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !out_free) |=> s1_valid_reg)
        else $error("read stage lost a beat while the output was stalled");

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        CNT_W'(col_reg) < eff_w)
        else $error("column counter beyond frame width");

    a_drain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        drain_reg <= eff_w)
        else $error("drain counter beyond frame width");

    a_drain_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (drain_reg != '0) |-> full)
        else $error("drain in progress while frame not full");

    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && is_drain && drain_last)
        |=> (row_reg == '0) && (drain_reg == '0) && (col_reg == '0))
        else $error("frame did not restart after its last drain");

endmodule

`default_nettype wire
